// ===== src/natural_order_string_compare_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef NATURAL_ORDER_STRING_COMPARE_MACROS_SVH
`define NATURAL_ORDER_STRING_COMPARE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NOSC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NOSC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nosc_pkg.sv =====
package nosc_pkg;

	localparam int MAX_LEN = 256;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int VAL_W   = 64;

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPARE = 2'd2;

	localparam logic signed [1:0] ORDER_LT = 2'sb11;
	localparam logic signed [1:0] ORDER_EQ = 2'sb00;
	localparam logic signed [1:0] ORDER_GT = 2'sb01;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_UC_A = 8'h41;
	localparam logic [7:0] CHAR_UC_Z = 8'h5A;
	localparam logic [7:0] CHAR_LC_A = 8'h61;
	localparam logic [7:0] CHAR_LC_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	// compare job handed from the loader to the engine
	typedef struct packed {
		logic [LEN_W-1:0] len_a;
		logic [LEN_W-1:0] len_b;
		logic             ovf;
	} cmd_t;

	// character store write
	typedef struct packed {
		logic             en_a;
		logic             en_b;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CHAR_UC_A) && (c <= CHAR_UC_Z);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || is_upper(c) || ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z));
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return is_upper(c) ? c + CASE_GAP : c;
	endfunction

	// v*10 + d, saturating at all ones
	function automatic logic [VAL_W-1:0] dec_step(input logic [VAL_W-1:0] v,
		input logic [3:0] d);
		logic [VAL_W+3:0] t;
		t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VAL_W{1'b0}}, d};
		return (t[VAL_W+3:VAL_W] != 4'b0) ? {VAL_W{1'b1}} : t[VAL_W-1:0];
	endfunction

endpackage

// ===== src/nosc_in_if.sv =====
interface nosc_in_if;
	import nosc_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink (input valid, input op, input ch, output ready);
endinterface

// ===== src/nosc_out_if.sv =====
interface nosc_out_if;
	logic              valid;
	logic              ready;
	logic signed [1:0] order;
	logic              truncated;

	modport source (output valid, output order, output truncated, input ready);
	modport sink (input valid, input order, input truncated, output ready);
endinterface

// ===== src/nosc_front.sv =====
module nosc_front
	import nosc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	nosc_in_if.sink    cmd,
	output wr_t        wr,
	output cmd_t       q_data,
	output logic       q_push,
	input  logic       q_full,
	input  logic       done
);

	logic [LEN_W-1:0] len_a_q;
	logic [LEN_W-1:0] len_b_q;
	logic             ovf_q;
	logic             busy_q;
	logic             accept;
	logic             full_a;
	logic             full_b;

	// hold off new words until the engine has finished reading the stores
	assign cmd.ready = !busy_q && !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign full_a    = (len_a_q == LEN_W'(MAX_LEN));
	assign full_b    = (len_b_q == LEN_W'(MAX_LEN));

	always_comb begin
		wr.en_a = accept && (cmd.op == OP_LOAD_A) && !full_a;
		wr.en_b = accept && (cmd.op == OP_LOAD_B) && !full_b;
		wr.addr = (cmd.op == OP_LOAD_A) ? len_a_q[IDX_W-1:0] : len_b_q[IDX_W-1:0];
		wr.data = cmd.ch;
	end

	assign q_push      = accept && (cmd.op == OP_COMPARE);
	assign q_data.len_a = len_a_q;
	assign q_data.len_b = len_b_q;
	assign q_data.ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (cmd.op)
					OP_LOAD_A: begin
						if (full_a) ovf_q <= 1'b1;
						else len_a_q <= len_a_q + 1'b1;
					end
					OP_LOAD_B: begin
						if (full_b) ovf_q <= 1'b1;
						else len_b_q <= len_b_q + 1'b1;
					end
					OP_COMPARE: begin
						len_a_q <= '0;
						len_b_q <= '0;
						ovf_q   <= 1'b0;
						busy_q  <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== src/nosc_fifo.sv =====
module nosc_fifo
	import nosc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t dout
);

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/nosc_engine.sv =====
module nosc_engine
	import nosc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  wr_t        wr,
	input  logic       q_empty,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       done,
	nosc_out_if.source res
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FETCH  = 6'b000010,
		S_EVAL   = 6'b000100,
		S_RFETCH = 6'b001000,
		S_REVAL  = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t            state_q;
	logic [7:0]        mem_a [MAX_LEN];
	logic [7:0]        mem_b [MAX_LEN];
	logic [7:0]        rd_a_q;
	logic [7:0]        rd_b_q;
	logic              inb_a_q;
	logic              inb_b_q;
	logic [LEN_W-1:0]  len_a_q;
	logic [LEN_W-1:0]  len_b_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  i_q;
	logic [LEN_W-1:0]  j_q;
	logic [VAL_W-1:0]  va_q;
	logic [VAL_W-1:0]  vb_q;
	logic [LEN_W-1:0]  na_q;
	logic [LEN_W-1:0]  nb_q;
	logic signed [1:0] order_q;
	logic              res_valid_q;
	logic signed [1:0] res_order_q;
	logic              res_trunc_q;
	logic [7:0]        c_a;
	logic [7:0]        c_b;
	logic              dig_a;
	logic              dig_b;
	logic              load_out;

	// character stores: one write from the loader, one registered read each
	always_ff @(posedge clk) begin
		if (wr.en_a) mem_a[wr.addr] <= wr.data;
		if (wr.en_b) mem_b[wr.addr] <= wr.data;
		rd_a_q  <= mem_a[i_q[IDX_W-1:0]];
		rd_b_q  <= mem_b[j_q[IDX_W-1:0]];
		inb_a_q <= (i_q < len_a_q);
		inb_b_q <= (j_q < len_b_q);
	end

	// past the stored length a string reads as NUL
	assign c_a   = inb_a_q ? rd_a_q : CHAR_NUL;
	assign c_b   = inb_b_q ? rd_b_q : CHAR_NUL;
	assign dig_a = is_digit(c_a);
	assign dig_b = is_digit(c_b);

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign load_out = (state_q == S_RESULT) && (!res_valid_q || res.ready);
	assign done     = load_out;

	assign res.valid     = res_valid_q;
	assign res.order     = res_order_q;
	assign res.truncated = res_trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (!q_empty) state_q <= S_FETCH;
				end
				S_FETCH: state_q <= S_EVAL;
				S_EVAL: begin
					if (c_a == c_b && !dig_a) begin
						state_q <= (c_a == CHAR_NUL) ? S_RESULT : S_FETCH;
					end else if (c_a == CHAR_NUL || c_b == CHAR_NUL) begin
						state_q <= S_RESULT;
					end else if (is_alnum(c_a) != is_alnum(c_b)) begin
						state_q <= S_RESULT;
					end else if (dig_a && dig_b) begin
						state_q <= S_RFETCH;
					end else begin
						state_q <= (fold(c_a) == fold(c_b)) ? S_FETCH : S_RESULT;
					end
				end
				S_RFETCH: state_q <= S_REVAL;
				S_REVAL: begin
					if (dig_a || dig_b) begin
						state_q <= S_RFETCH;
					end else if (va_q != vb_q || na_q != nb_q) begin
						state_q <= S_RESULT;
					end else begin
						// both runs ended on the chars already in the read registers
						state_q <= S_EVAL;
					end
				end
				S_RESULT: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_order_q <= order_q;
			res_trunc_q <= ovf_q;
		end
		case (state_q)
			S_IDLE: begin
				len_a_q <= q_data.len_a;
				len_b_q <= q_data.len_b;
				ovf_q   <= q_data.ovf;
				i_q     <= '0;
				j_q     <= '0;
			end
			S_EVAL: begin
				if (c_a == c_b && !dig_a) begin
					order_q <= ORDER_EQ;
					i_q     <= i_q + 1'b1;
					j_q     <= j_q + 1'b1;
				end else if (c_a == CHAR_NUL) begin
					order_q <= ORDER_LT;
				end else if (c_b == CHAR_NUL) begin
					order_q <= ORDER_GT;
				end else if (!is_alnum(c_a) && is_alnum(c_b)) begin
					order_q <= ORDER_LT;
				end else if (is_alnum(c_a) && !is_alnum(c_b)) begin
					order_q <= ORDER_GT;
				end else if (dig_a && dig_b) begin
					va_q <= {{(VAL_W-4){1'b0}}, c_a[3:0]};
					vb_q <= {{(VAL_W-4){1'b0}}, c_b[3:0]};
					na_q <= LEN_W'(1);
					nb_q <= LEN_W'(1);
					i_q  <= i_q + 1'b1;
					j_q  <= j_q + 1'b1;
				end else begin
					order_q <= (fold(c_a) < fold(c_b)) ? ORDER_LT : ORDER_GT;
					i_q     <= i_q + 1'b1;
					j_q     <= j_q + 1'b1;
				end
			end
			S_REVAL: begin
				if (dig_a) begin
					va_q <= dec_step(va_q, c_a[3:0]);
					na_q <= na_q + 1'b1;
					i_q  <= i_q + 1'b1;
				end
				if (dig_b) begin
					vb_q <= dec_step(vb_q, c_b[3:0]);
					nb_q <= nb_q + 1'b1;
					j_q  <= j_q + 1'b1;
				end
				if (!dig_a && !dig_b) begin
					// equal value: the longer run sorts first
					if (va_q < vb_q) order_q <= ORDER_LT;
					else if (va_q > vb_q) order_q <= ORDER_GT;
					else if (na_q > nb_q) order_q <= ORDER_LT;
					else order_q <= ORDER_GT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/natural_order_string_compare.sv =====
// Natural-order compare of two byte strings.
// cmd channel: op 0 appends ch to the first string, op 1 to the second, op 2
// compares; op 3 is taken and ignored. res channel: one word per compare with
// order (-1, 0, 1 as signed 2 bits) and truncated.
// Appends are taken one per cycle while no compare runs. Each string holds
// 256 bytes; bytes beyond that are dropped and set truncated on the next
// result. A NUL byte ends a string early.
// A compare walks both stores through one registered read port each: every
// matching character or digit-run step passes a fetch and an evaluate state,
// until the result sits in the output register. While a compare runs,
// cmd.ready stays low; it rises again in the cycle after the result is
// loaded, and both strings are then empty.
// A result waits in the output register while res.ready is low; the engine
// then holds its next result until the register frees.
// Reset empties both strings and drops any pending compare; the store
// contents are not cleared and need no clearing pass.
module natural_order_string_compare
	import nosc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	nosc_in_if.sink    cmd,
	nosc_out_if.source res
);

	wr_t  wr;
	cmd_t push_data;
	cmd_t pop_data;
	logic push;
	logic full;
	logic pop;
	logic empty;
	logic done;

	nosc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wr     (wr),
		.q_data (push_data),
		.q_push (push),
		.q_full (full),
		.done   (done)
	);

	nosc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.dout   (pop_data)
	);

	nosc_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_empty (empty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.done    (done),
		.res     (res)
	);

endmodule

// ===== src/nosc_checker.sv =====
`include "natural_order_string_compare_macros.svh"

module nosc_checker
	import nosc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [1:0]        cmd_op,
	input logic              res_valid,
	input logic              res_ready,
	input logic signed [1:0] res_order
);

	`NOSC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped while stalled")
	`NOSC_ASSERT_IMP(a_order_legal, res_valid, res_order == ORDER_LT || res_order == ORDER_EQ || res_order == ORDER_GT, "illegal order code")
	`NOSC_ASSERT_NXT(a_busy_after_cmp, cmd_valid && cmd_ready && cmd_op == OP_COMPARE, !cmd_ready, "input taken right after a compare")

endmodule

bind natural_order_string_compare nosc_checker u_nosc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_op    (cmd.op),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_order (res.order)
);
